FILE: rtl/esa_pkg.sv
// Shared types, constants and step-size lookups for the encoder setpoint adjuster.
// No dependencies.
package esa_pkg;

  localparam int unsigned VoltSpW   = 15;
  localparam int unsigned CurrSpW   = 12;
  localparam int unsigned LevelW    = 2;
  localparam int unsigned ClicksW   = 8;
  localparam int unsigned SumW      = 18;  // holds setpoint + clicks * step, signed
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 40;

  localparam logic [VoltSpW-1:0] VoltMaxMv = 15'd30000;
  localparam logic [CurrSpW-1:0] CurrMaxMa = 12'd3000;

  localparam logic [LevelW-1:0] LevelCoarse = 2'd0;
  localparam logic [LevelW-1:0] LevelFine   = 2'd1;
  localparam logic [LevelW-1:0] LevelLocked = 2'd2;

  typedef struct packed {
    logic                      volt_button_down;
    logic                      curr_button_down;
    logic signed [ClicksW-1:0] volt_clicks;
    logic signed [ClicksW-1:0] curr_clicks;
  } esa_item_t;

  typedef struct packed {
    logic [VoltSpW-1:0] volt_setpoint;
    logic [CurrSpW-1:0] curr_setpoint;
    logic [LevelW-1:0]  volt_step_level;
    logic [LevelW-1:0]  curr_step_level;
    logic               level_changed;
    logic               setpoint_touched;
  } esa_result_t;

  // Voltage step in mV for a level; the unused code gives no step.
  function automatic logic [7:0] volt_step(input logic [LevelW-1:0] lvl);
    logic [7:0] s;
    case (lvl)
      LevelCoarse: s = 8'd200;
      LevelFine:   s = 8'd10;
      LevelLocked: s = 8'd0;
      default:     s = 8'd0;
    endcase
    return s;
  endfunction

  // Current step in mA for a level.
  function automatic logic [7:0] curr_step(input logic [LevelW-1:0] lvl);
    logic [7:0] s;
    case (lvl)
      LevelCoarse: s = 8'd100;
      LevelFine:   s = 8'd1;
      LevelLocked: s = 8'd0;
      default:     s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/encoder_setpoint_adjuster.sv
// Top level of the encoder setpoint adjuster: input register, update stage, result register.
// Depends on esa_pkg and esa_update.
//
//   channel   direction  fields (tdata, lowest bit first)
//   s_axis    in         volt_button_down, curr_button_down, volt_clicks, curr_clicks
//   m_axis    out        volt_setpoint, curr_setpoint, volt_step_level, curr_step_level,
//                        level_changed, setpoint_touched
//
// One scan tick per cycle unless output stalls; a tick goes via input then result register.
// The input register and the result register each hold one item, so a new tick is
// taken while a result waits. A stalled output fills the result register and then the
// input register, after which s_axis_tready drops. Reset clears setpoints and levels
// to zero (coarse) and both button histories to not pressed.
module encoder_setpoint_adjuster #(
  parameter int unsigned STEP_LEVELS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] volt_button_down, [1] curr_button_down, [9:2] volt_clicks, [17:10] curr_clicks
  input  logic [esa_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [14:0] volt_setpoint, [26:15] curr_setpoint, [28:27] volt_step_level,
  // [30:29] curr_step_level, [31] level_changed, [32] setpoint_touched
  output logic [esa_pkg::OutDataW-1:0] m_axis_tdata
);
  import esa_pkg::*;

  logic        in_valid_q;
  esa_item_t   in_item_q;
  logic        out_valid_q;
  esa_result_t out_res_q;
  esa_result_t res;
  logic        adv;

  // Advance the held tick when the result register is free or being emptied
  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;

  esa_update #(
    .StepLevels (STEP_LEVELS)
  ) u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (in_item_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.volt_button_down <= s_axis_tdata[0];
      in_item_q.curr_button_down <= s_axis_tdata[1];
      in_item_q.volt_clicks      <= s_axis_tdata[9:2];
      in_item_q.curr_clicks      <= s_axis_tdata[17:10];
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0,
                          out_res_q.setpoint_touched,
                          out_res_q.level_changed,
                          out_res_q.curr_step_level,
                          out_res_q.volt_step_level,
                          out_res_q.curr_setpoint,
                          out_res_q.volt_setpoint};

endmodule

FILE: rtl/esa_update.sv
// Setpoint and step-level state with the per-tick update logic.
// Depends on esa_pkg.
module esa_update #(
  parameter int unsigned StepLevels = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  esa_pkg::esa_item_t   item_i,
  output esa_pkg::esa_result_t result_o
);
  import esa_pkg::*;

  logic [VoltSpW-1:0] volt_target_q, volt_target_d;
  logic [CurrSpW-1:0] curr_target_q, curr_target_d;
  logic [LevelW-1:0]  volt_level_q, volt_level_d;
  logic [LevelW-1:0]  curr_level_q, curr_level_d;
  logic               volt_btn_q, curr_btn_q;

  logic               volt_rel, curr_rel, touched;
  logic [LevelW:0]    volt_inc, curr_inc;
  logic signed [SumW-1:0] volt_sum, curr_sum;

  always_comb begin
    volt_rel = volt_btn_q & ~item_i.volt_button_down;
    curr_rel = curr_btn_q & ~item_i.curr_button_down;

    // Advance the level on release, wrapping after the last one
    volt_inc = {1'b0, volt_level_q} + (LevelW+1)'(1);
    curr_inc = {1'b0, curr_level_q} + (LevelW+1)'(1);
    volt_level_d = volt_level_q;
    curr_level_d = curr_level_q;
    if (volt_rel) begin
      volt_level_d = (volt_inc >= (LevelW+1)'(StepLevels)) ? LevelCoarse : volt_inc[LevelW-1:0];
    end
    if (curr_rel) begin
      curr_level_d = (curr_inc >= (LevelW+1)'(StepLevels)) ? LevelCoarse : curr_inc[LevelW-1:0];
    end

    touched = (item_i.volt_clicks != '0) || (item_i.curr_clicks != '0);

    // Clicks use the step size of the level after any advance
    volt_sum = SumW'(signed'({1'b0, volt_target_q}))
             + SumW'(item_i.volt_clicks) * SumW'(signed'({1'b0, volt_step(volt_level_d)}));
    curr_sum = SumW'(signed'({1'b0, curr_target_q}))
             + SumW'(item_i.curr_clicks) * SumW'(signed'({1'b0, curr_step(curr_level_d)}));

    volt_target_d = volt_target_q;
    curr_target_d = curr_target_q;
    if (touched) begin
      if (volt_sum < 0) begin
        volt_target_d = '0;
      end else if (volt_sum > SumW'(signed'({1'b0, VoltMaxMv}))) begin
        volt_target_d = VoltMaxMv;
      end else begin
        volt_target_d = volt_sum[VoltSpW-1:0];
      end
      if (curr_sum < 0) begin
        curr_target_d = '0;
      end else if (curr_sum > SumW'(signed'({1'b0, CurrMaxMa}))) begin
        curr_target_d = CurrMaxMa;
      end else begin
        curr_target_d = curr_sum[CurrSpW-1:0];
      end
    end

    result_o.volt_setpoint    = volt_target_d;
    result_o.curr_setpoint    = curr_target_d;
    result_o.volt_step_level  = volt_level_d;
    result_o.curr_step_level  = curr_level_d;
    result_o.level_changed    = volt_rel | curr_rel;
    result_o.setpoint_touched = touched;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_target_q <= '0;
      curr_target_q <= '0;
      volt_level_q  <= LevelCoarse;
      curr_level_q  <= LevelCoarse;
      volt_btn_q    <= 1'b0;
      curr_btn_q    <= 1'b0;
    end else if (adv_i) begin
      volt_target_q <= volt_target_d;
      curr_target_q <= curr_target_d;
      volt_level_q  <= volt_level_d;
      curr_level_q  <= curr_level_d;
      volt_btn_q    <= item_i.volt_button_down;
      curr_btn_q    <= item_i.curr_button_down;
    end
  end

endmodule
